[hw/rtl/hashed_flow_table_unit_defines.svh]
// assertion macros for the hashed flow table unit
// expects clk and rst_n in the scope of use; no other dependencies
`ifndef HASHED_FLOW_TABLE_UNIT_DEFINES_SVH
`define HASHED_FLOW_TABLE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define HFT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define HFT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HFT_ASSERT_IMP(lbl, ante, cons, msg)
`define HFT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[hw/rtl/hft_pkg.sv]
// shared types, codes and sizes of the hashed flow table unit
// no dependencies
`timescale 1ns / 1ps

package hft_pkg;

    localparam int BUCKETS      = 31;
    localparam int BUCKET_W     = 5;
    localparam int BUCKET_DEPTH = 512;
    localparam int HASH_W       = 26;
    localparam int FIELDS       = 5;
    localparam int FLD_W        = 3;
    localparam int REDUCE_STEPS = HASH_W / 2;
    localparam int STEP_W       = 4;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic [2:0] RSP_INSERTED = 3'd0;
    localparam logic [2:0] RSP_FULL     = 3'd1;
    localparam logic [2:0] RSP_FOUND    = 3'd2;
    localparam logic [2:0] RSP_MISS     = 3'd3;
    localparam logic [2:0] RSP_CLEARED  = 3'd4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  ip_proto;
    } hft_req_t;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  ip_proto;
    } hft_tuple_t;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] bucket;
    } hft_rsp_t;

    typedef struct packed {
        logic                done;
        logic [BUCKET_W-1:0] bucket;
    } hft_hash_rsp_t;

endpackage

[hw/rtl/hft_ram.sv]
// generic single-port synchronous ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module hft_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/hft_hash.sv]
// chained five-tuple hash and bucket reduction, each field through a prep and a mix state,
// then two remainder bits per cycle; depends on hft_pkg and the defines header
`timescale 1ns / 1ps
`include "hashed_flow_table_unit_defines.svh"

module hft_hash (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  hft_pkg::hft_tuple_t   tup,
    output hft_pkg::hft_hash_rsp_t rsp
);

    import hft_pkg::*;

    localparam int MOD_W = 23;
    localparam logic [MOD_W:0] HASH_MOD = 24'h7fffff;

    localparam logic [FLD_W-1:0] FLD_SRC_ADDR = 3'd0;
    localparam logic [FLD_W-1:0] FLD_SRC_PORT = 3'd1;
    localparam logic [FLD_W-1:0] FLD_DST_ADDR = 3'd2;
    localparam logic [FLD_W-1:0] FLD_DST_PORT = 3'd3;
    localparam logic [FLD_W-1:0] FLD_PROTO    = 3'd4;
    localparam logic [FLD_W-1:0] FLD_LAST     = FLD_W'(FIELDS - 1);
    localparam logic [STEP_W-1:0] STEP_LAST   = STEP_W'(REDUCE_STEPS - 1);

    typedef enum logic [1:0] {H_IDLE, H_PREP, H_MIX, H_RED} hstate_t;

    hstate_t             state_reg, state_next;
    logic [FLD_W-1:0]    fld_reg, fld_next;
    logic [HASH_W-1:0]   h_reg, h_next;
    logic [MOD_W-1:0]    xr_reg, xr_next;
    logic [31:0]         m_reg, m_next;
    logic [HASH_W-1:0]   sh_reg, sh_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic [BUCKET_W-1:0] rem_reg, rem_next;
    logic                done_reg, done_next;
    logic [31:0]         fld_x;

    function automatic logic [MOD_W-1:0] mod_hash(input logic [31:0] v);
        logic [MOD_W:0] s;
        s = {1'b0, v[MOD_W-1:0]} + (MOD_W + 1)'(v[31:MOD_W]);
        if (s >= HASH_MOD)
        begin
            s = s - HASH_MOD;
        end
        return s[MOD_W-1:0];
    endfunction

    function automatic logic [BUCKET_W-1:0] rem_step(input logic [BUCKET_W-1:0] r,
                                                     input logic [1:0] b);
        logic [BUCKET_W:0]   t;
        logic [BUCKET_W-1:0] q;
        q = r;
        for (int k = 1; k >= 0; k--)
        begin
            t = {q, b[k]};
            if (t >= (BUCKET_W + 1)'(BUCKETS))
            begin
                t = t - (BUCKET_W + 1)'(BUCKETS);
            end
            q = t[BUCKET_W-1:0];
        end
        return q;
    endfunction

    always_comb
    begin
        case (fld_reg)
            FLD_SRC_ADDR: fld_x = tup.src_addr;
            FLD_SRC_PORT: fld_x = {16'b0, tup.src_port};
            FLD_DST_ADDR: fld_x = tup.dst_addr;
            FLD_DST_PORT: fld_x = {16'b0, tup.dst_port};
            FLD_PROTO:    fld_x = {24'b0, tup.ip_proto};
            default:      fld_x = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        fld_next   = fld_reg;
        h_next     = h_reg;
        xr_next    = xr_reg;
        m_next     = m_reg;
        sh_next    = sh_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        done_next  = 1'b0;
        case (state_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    h_next     = '0;
                    fld_next   = FLD_SRC_ADDR;
                    state_next = H_PREP;
                end
            end
            H_PREP:
            begin
                xr_next    = mod_hash(fld_x);
                m_next     = (32'(h_reg) << 5) + 32'(h_reg);
                state_next = H_MIX;
            end
            H_MIX:
            begin
                h_next = h_reg + HASH_W'(mod_hash(m_reg + 32'(xr_reg)));
                if (fld_reg == FLD_LAST)
                begin
                    sh_next    = h_next;
                    cnt_next   = '0;
                    rem_next   = '0;
                    state_next = H_RED;
                end
                else
                begin
                    fld_next   = fld_reg + 1'b1;
                    state_next = H_PREP;
                end
            end
            H_RED:
            begin
                rem_next = rem_step(rem_reg, sh_reg[HASH_W-1 -: 2]);
                sh_next  = sh_reg << 2;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_LAST)
                begin
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fld_reg <= fld_next;
        h_reg   <= h_next;
        xr_reg  <= xr_next;
        m_reg   <= m_next;
        sh_reg  <= sh_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.bucket = rem_reg;

    `HFT_ASSERT_IMP(a_xr_reduced, state_reg == H_MIX, xr_reg < HASH_MOD[MOD_W-1:0], "field residue out of range")
    `HFT_ASSERT_IMP(a_bucket_range, done_reg, rem_reg < BUCKET_W'(BUCKETS), "bucket out of range")
    `HFT_ASSERT_NXT(a_done_pulse, done_reg, !done_reg && state_reg == H_IDLE, "done held too long")

endmodule

[hw/rtl/hashed_flow_table_unit.sv]
// five-tuple connection table: request control, bucket fill memory, entry memory
// depends on hft_pkg, hft_ram, hft_hash and the defines header
// request flow: a clear goes straight to the response state; insert and match wait for the hash,
// read the bucket fill, then insert writes the entry unless full and match scans to a hit or the fill
// throughput: one request at a time, match set by the one-entry-per-cycle entry memory scan
// reset: control, output valid and per-bucket valid bits clear at once, no clearing pass
`timescale 1ns / 1ps
`include "hashed_flow_table_unit_defines.svh"

module hashed_flow_table_unit #(
    parameter int BUCKET_DEPTH = hft_pkg::BUCKET_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  hft_pkg::hft_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output hft_pkg::hft_rsp_t rsp
);

    import hft_pkg::*;

    localparam int FILL_W    = $clog2(BUCKET_DEPTH + 1);
    localparam int ENT_DEPTH = BUCKETS * BUCKET_DEPTH;
    localparam int ENT_AW    = $clog2(ENT_DEPTH);
    localparam int TUP_W     = $bits(hft_tuple_t);

    typedef enum logic [2:0] {ST_IDLE, ST_HASH, ST_FILL_RD, ST_FILL, ST_SCAN, ST_DONE} state_t;

    state_t              state_reg, state_next;
    logic [1:0]          cmd_reg, cmd_next;
    hft_tuple_t          tup_reg, tup_next;
    logic [BUCKET_W-1:0] bucket_reg, bucket_next;
    logic [ENT_AW-1:0]   base_reg, base_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [FILL_W-1:0]   idx_reg, idx_next;
    logic                pend_reg, pend_next;
    hft_rsp_t            res_reg, res_next;
    hft_rsp_t            rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [BUCKETS-1:0]  fill_vld_reg, fill_vld_next;

    hft_hash_rsp_t     hash_rsp;
    logic              hash_start;
    logic              ent_we;
    logic [ENT_AW-1:0] ent_addr;
    logic [TUP_W-1:0]  ent_rdata;
    logic              fill_we;
    logic [FILL_W-1:0] fill_rdata;
    logic [FILL_W-1:0] fill_cur;
    logic              scan_re;
    logic              hit;

    assign req_stall  = (state_reg != ST_IDLE);
    assign hash_start = req_valid && !req_stall && (req.cmd != CMD_CLEAR);
    assign fill_cur   = fill_vld_reg[bucket_reg] ? fill_rdata : '0;
    assign scan_re    = (idx_reg < fill_reg);
    assign hit        = pend_reg && (hft_tuple_t'(ent_rdata) == tup_reg);
    assign ent_addr   = base_reg + ENT_AW'((state_reg == ST_FILL) ? fill_cur : idx_reg);

    hft_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .tup   (tup_reg),
        .rsp   (hash_rsp)
    );

    hft_ram #(
        .WIDTH (FILL_W),
        .DEPTH (BUCKETS)
    ) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .addr  (bucket_reg),
        .wdata (fill_cur + 1'b1),
        .rdata (fill_rdata)
    );

    hft_ram #(
        .WIDTH (TUP_W),
        .DEPTH (ENT_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .addr  (ent_addr),
        .wdata (tup_reg),
        .rdata (ent_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        tup_next       = tup_reg;
        bucket_next    = bucket_reg;
        base_next      = base_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        fill_vld_next  = fill_vld_reg;
        ent_we         = 1'b0;
        fill_we        = 1'b0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next          = req.cmd;
                    tup_next.src_addr = req.src_addr;
                    tup_next.dst_addr = req.dst_addr;
                    tup_next.src_port = req.src_port;
                    tup_next.dst_port = req.dst_port;
                    tup_next.ip_proto = (req.ip_proto == PROTO_TCP || req.ip_proto == PROTO_UDP)
                                        ? req.ip_proto : 8'd0;
                    if (req.cmd == CMD_CLEAR)
                    begin
                        fill_vld_next   = '0;
                        res_next.status = RSP_CLEARED;
                        res_next.bucket = '0;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH:
            begin
                if (hash_rsp.done)
                begin
                    bucket_next = hash_rsp.bucket;
                    state_next  = ST_FILL_RD;
                end
            end
            ST_FILL_RD:
            begin
                base_next  = ENT_AW'(bucket_reg) * ENT_AW'(BUCKET_DEPTH);
                state_next = ST_FILL;
            end
            ST_FILL:
            begin
                fill_next       = fill_cur;
                idx_next        = '0;
                pend_next       = 1'b0;
                res_next.bucket = 5'(bucket_reg);
                if (cmd_reg == CMD_INSERT)
                begin
                    if (fill_cur >= FILL_W'(BUCKET_DEPTH))
                    begin
                        res_next.status = RSP_FULL;
                    end
                    else
                    begin
                        ent_we                    = 1'b1;
                        fill_we                   = 1'b1;
                        fill_vld_next[bucket_reg] = 1'b1;
                        res_next.status           = RSP_INSERTED;
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                pend_next = scan_re;
                if (scan_re)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (hit)
                begin
                    res_next.status = RSP_FOUND;
                    state_next      = ST_DONE;
                end
                else if (!scan_re && !pend_reg)
                begin
                    res_next.status = RSP_MISS;
                    state_next      = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            fill_vld_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
            fill_vld_reg  <= fill_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        tup_reg    <= tup_next;
        bucket_reg <= bucket_next;
        base_reg   <= base_next;
        fill_reg   <= fill_next;
        idx_reg    <= idx_next;
        pend_reg   <= pend_next;
        res_reg    <= res_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `HFT_ASSERT_IMP(a_done_in_hash, hash_rsp.done, state_reg == ST_HASH, "hash done outside hash wait")
    `HFT_ASSERT_IMP(a_scan_bound, state_reg == ST_SCAN, idx_reg <= fill_reg, "scan past bucket fill")
    `HFT_ASSERT_IMP(a_fill_bound, state_reg == ST_FILL, fill_cur <= FILL_W'(BUCKET_DEPTH), "bucket fill too large")
    `HFT_ASSERT_IMP(a_found_cmd, state_reg == ST_DONE && res_reg.status == RSP_FOUND, cmd_reg != CMD_INSERT, "match result on insert")

endmodule

[sim/hashed_flow_table_unit_test.sv]
// self-checking testbench of the hashed flow table unit: directed, bucket-fill and random requests
// predicts every response from its own copy of the bucket contents; depends on hft_pkg and the rtl
`timescale 1ns / 1ps

module hashed_flow_table_unit_test;
    import hft_pkg::*;

    localparam logic [1:0] CMD_MATCH = 2'd1;
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam longint unsigned HASH_MOD = 64'h7f_ffff;
    localparam longint unsigned HASH_MUL = 64'd33;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 600;
    localparam int RANDOM_REQUESTS = 620;

    class flow_table_scoreboard;
        hft_tuple_t bucket_entries[BUCKETS][$];
        hft_rsp_t   awaited_rsp[$];
        int         status_count[8];
        int         mismatches;
        int         responses_checked;

        function hft_tuple_t canonical(hft_tuple_t t);
            hft_tuple_t c;
            c = t;
            if (t.ip_proto != PROTO_TCP && t.ip_proto != PROTO_UDP)
                c.ip_proto = '0;
            return c;
        endfunction

        function logic [BUCKET_W-1:0] predict_bucket(hft_tuple_t t);
            hft_tuple_t c;
            longint unsigned fld[5];
            longint unsigned h;
            c = canonical(t);
            fld[0] = 64'(c.src_addr);
            fld[1] = 64'(c.src_port);
            fld[2] = 64'(c.dst_addr);
            fld[3] = 64'(c.dst_port);
            fld[4] = 64'(c.ip_proto);
            h = 0;
            for (int i = 0; i < 5; i++)
                h = h + ((HASH_MUL * h + fld[i] % HASH_MOD) % HASH_MOD);
            return BUCKET_W'(h % BUCKETS);
        endfunction

        function void note_request(hft_req_t r);
            hft_tuple_t t;
            hft_rsp_t   e;
            int         b;
            t.src_addr = r.src_addr;
            t.dst_addr = r.dst_addr;
            t.src_port = r.src_port;
            t.dst_port = r.dst_port;
            t.ip_proto = r.ip_proto;
            if (r.cmd == CMD_CLEAR)
            begin
                for (int i = 0; i < BUCKETS; i++)
                    bucket_entries[i].delete();
                e.status = RSP_CLEARED;
                e.bucket = '0;
            end
            else
            begin
                t = canonical(t);
                e.bucket = predict_bucket(t);
                b = int'(e.bucket);
                if (r.cmd == CMD_INSERT)
                begin
                    if (bucket_entries[b].size() >= BUCKET_DEPTH)
                        e.status = RSP_FULL;
                    else
                    begin
                        bucket_entries[b].push_back(t);
                        e.status = RSP_INSERTED;
                    end
                end
                else
                begin
                    e.status = RSP_MISS;
                    for (int i = 0; i < bucket_entries[b].size(); i++)
                        if (bucket_entries[b][i] == t)
                            e.status = RSP_FOUND;
                end
            end
            status_count[e.status]++;
            awaited_rsp.push_back(e);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_response(hft_rsp_t got);
            hft_rsp_t e;
            responses_checked++;
            if (awaited_rsp.size() == 0)
            begin
                report_mismatch($sformatf("unexpected response status %0d bucket %0d",
                                          got.status, got.bucket));
                return;
            end
            e = awaited_rsp.pop_front();
            if (got.status !== e.status)
                report_mismatch($sformatf("response %0d status %0d, want %0d",
                                          responses_checked, got.status, e.status));
            if (got.bucket !== e.bucket)
                report_mismatch($sformatf("response %0d bucket %0d, want %0d",
                                          responses_checked, got.bucket, e.bucket));
        endtask
    endclass

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    hft_req_t req;
    logic     rsp_valid;
    logic     rsp_stall;
    hft_rsp_t rsp;

    flow_table_scoreboard sb;
    int         requests_sent;
    int         responses_seen;
    bit         hold_off_armed;
    hft_tuple_t flow_pool[$];

    hashed_flow_table_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #200_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // every third window of 48 requests runs with no idling
    function automatic int idle_draw(int count);
        if ((count / 48) % 3 == 2)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic hft_tuple_t random_flow();
        hft_tuple_t t;
        t.src_addr = $urandom;
        t.dst_addr = $urandom;
        t.src_port = 16'($urandom_range(0, 16'hffff));
        t.dst_port = 16'($urandom_range(0, 16'hffff));
        case ($urandom_range(0, 3))
            0:       t.ip_proto = PROTO_TCP;
            1:       t.ip_proto = PROTO_UDP;
            default: t.ip_proto = 8'($urandom_range(0, 255));
        endcase
        return t;
    endfunction

    task automatic send_request(logic [1:0] cmd, hft_tuple_t t);
        hft_req_t r;
        int       gap;
        r.cmd      = cmd;
        r.src_addr = t.src_addr;
        r.dst_addr = t.dst_addr;
        r.src_port = t.src_port;
        r.dst_port = t.dst_port;
        r.ip_proto = t.ip_proto;
        gap = idle_draw(requests_sent);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(r);
        requests_sent++;
        @(negedge clk);
    endtask

    // response side
    initial
    begin
        int gap;
        bit hold_off_done;
        hold_off_done = 1'b0;
        rsp_stall     = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = idle_draw(responses_seen);
            if (hold_off_armed && !hold_off_done)
            begin
                gap = HOLD_OFF_CYCLES;
                hold_off_done = 1'b1;
            end
            if (gap > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
            sb.check_response(rsp);
            responses_seen++;
            @(negedge clk);
        end
    end

    initial
    begin
        hft_tuple_t       t;
        hft_tuple_t       u;
        hft_tuple_t       zero_flow;
        hft_tuple_t       ones_flow;
        hft_tuple_t       tcp_flow;
        hft_tuple_t       udp_flow;
        hft_tuple_t       fill_flows[$];
        logic [BUCKET_W-1:0] target;
        logic [1:0]       cmd;
        int               pick;
        int               idx;

        sb = new();
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req            = '0;
        hold_off_armed = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed requests
        zero_flow = '0;
        ones_flow = '1;
        tcp_flow  = '{src_addr: 32'h0a00_0001, dst_addr: 32'hc0a8_0101,
                      src_port: 16'd49152, dst_port: 16'd443, ip_proto: PROTO_TCP};
        udp_flow  = '{src_addr: 32'h8000_0000, dst_addr: 32'h7fff_ffff,
                      src_port: 16'd53, dst_port: 16'hffff, ip_proto: PROTO_UDP};
        send_request(CMD_MATCH, zero_flow);
        send_request(CMD_INSERT, zero_flow);
        send_request(CMD_INSERT, ones_flow);
        u = ones_flow;
        u.ip_proto = 8'd0;
        send_request(CMD_MATCH, u);
        u = zero_flow;
        u.ip_proto = 8'hff;
        send_request(CMD_MATCH, u);
        send_request(CMD_INSERT, tcp_flow);
        u = tcp_flow;
        u.ip_proto = PROTO_UDP;
        send_request(CMD_MATCH, u);
        send_request(CMD_MATCH, tcp_flow);
        send_request(CMD_INSERT, udp_flow);
        send_request(CMD_INSERT, udp_flow);
        send_request(CMD_MATCH, udp_flow);
        u = tcp_flow;
        u.dst_port = u.dst_port ^ 16'd1;
        send_request(CMD_MATCH, u);
        send_request(CMD_SPARE, tcp_flow);
        send_request(CMD_SPARE, u);
        u = tcp_flow;
        u.src_port = 16'hffff;
        send_request(CMD_MATCH, u);
        send_request(CMD_CLEAR, ones_flow);
        send_request(CMD_MATCH, tcp_flow);
        send_request(CMD_INSERT, tcp_flow);
        send_request(CMD_MATCH, tcp_flow);
        send_request(CMD_CLEAR, zero_flow);

        // fill one bucket to the limit, partly with duplicates
        target = sb.predict_bucket(random_flow());
        for (int n = 0; n < BUCKET_DEPTH; n++)
        begin
            if (n > 0 && $urandom_range(0, 3) == 0)
                t = fill_flows[$urandom_range(0, fill_flows.size() - 1)];
            else
            begin
                do
                    t = random_flow();
                while (sb.predict_bucket(t) != target);
                fill_flows.push_back(t);
            end
            send_request(CMD_INSERT, t);
        end
        send_request(CMD_MATCH, fill_flows[0]);
        send_request(CMD_MATCH, fill_flows[fill_flows.size() - 1]);
        do
            t = random_flow();
        while (sb.predict_bucket(t) != target);
        send_request(CMD_MATCH, t);
        send_request(CMD_INSERT, t);
        send_request(CMD_INSERT, fill_flows[0]);
        send_request(CMD_SPARE, fill_flows[fill_flows.size() - 1]);
        do
            u = random_flow();
        while (sb.predict_bucket(u) == target);
        send_request(CMD_INSERT, u);
        send_request(CMD_MATCH, u);
        send_request(CMD_CLEAR, random_flow());
        send_request(CMD_INSERT, fill_flows[1]);
        send_request(CMD_MATCH, fill_flows[0]);
        send_request(CMD_MATCH, fill_flows[1]);

        // random traffic: inserts, lookups of known flows, near misses, clears and noise
        hold_off_armed = 1'b1;
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                if (flow_pool.size() > 0 && $urandom_range(0, 3) == 0)
                    t = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
                else
                    t = random_flow();
                send_request(CMD_INSERT, t);
                flow_pool.push_back(t);
            end
            else if (pick < 84)
            begin
                pick = $urandom_range(0, 9);
                if (flow_pool.size() > 0 && pick < 7)
                begin
                    t = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
                    if (pick >= 5)
                    begin
                        // flip one bit of one field
                        case ($urandom_range(0, 4))
                            0:
                            begin
                                idx = $urandom_range(0, 31);
                                t.src_addr[idx] = ~t.src_addr[idx];
                            end
                            1:
                            begin
                                idx = $urandom_range(0, 31);
                                t.dst_addr[idx] = ~t.dst_addr[idx];
                            end
                            2:
                            begin
                                idx = $urandom_range(0, 15);
                                t.src_port[idx] = ~t.src_port[idx];
                            end
                            3:
                            begin
                                idx = $urandom_range(0, 15);
                                t.dst_port[idx] = ~t.dst_port[idx];
                            end
                            default:
                            begin
                                idx = $urandom_range(0, 7);
                                t.ip_proto[idx] = ~t.ip_proto[idx];
                            end
                        endcase
                    end
                end
                else
                    t = random_flow();
                cmd = ($urandom_range(0, 9) == 0) ? CMD_SPARE : CMD_MATCH;
                send_request(cmd, t);
            end
            else if (pick < 87)
            begin
                send_request(CMD_CLEAR, random_flow());
                flow_pool.delete();
            end
            else
            begin
                cmd = 2'($urandom_range(0, 3));
                send_request(cmd, random_flow());
                if (cmd == CMD_CLEAR)
                    flow_pool.delete();
            end
        end
        req_valid <= 1'b0;

        while (sb.awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests: %0d inserted, %0d bucket full, %0d found, %0d no match, %0d cleared",
                 requests_sent, sb.status_count[RSP_INSERTED], sb.status_count[RSP_FULL],
                 sb.status_count[RSP_FOUND], sb.status_count[RSP_MISS],
                 sb.status_count[RSP_CLEARED]);
        $display("%0d responses checked, %0d mismatches, one bucket driven to %0d entries",
                 sb.responses_checked, sb.mismatches, BUCKET_DEPTH);
        if (sb.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
